>>> rtl/ukst_pkg.sv
// ----------------------------------------------------------------------------
// ukst_pkg
// Shared types, codes and defaults of the unique key set table.
// ----------------------------------------------------------------------------
package ukst_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int KEY_OUT_W   = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_DUP    = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // per-cell command from the sequencer
    typedef struct packed {
        logic cmp;   // latch compare flags against the presented key
        logic ins;   // open a gap and place the key
        logic rem;   // close the gap at the matching entry
    } t_cell_ctrl;

    // per-cell status handed to the neighbour and the sequencer
    typedef struct packed {
        logic valid;
        logic lt;    // presented key is below the held key
        logic eq;    // presented key equals the held key
    } t_cell_stat;

endpackage

>>> rtl/ukst_cell.sv
// ----------------------------------------------------------------------------
// ukst_cell
// One entry of the sorted key chain: holds a key, compares, shifts.
// ----------------------------------------------------------------------------
module ukst_cell
    import ukst_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctrl           i_ctrl,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [KEY_WIDTH-1:0] i_left_key,
    input  t_cell_stat           i_left_stat,
    input  logic [KEY_WIDTH-1:0] i_right_key,
    input  logic                 i_right_valid,
    output logic [KEY_WIDTH-1:0] o_key,
    output t_cell_stat           o_stat
);

    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic                 r_valid, n_valid;
    logic                 r_lt, n_lt;
    logic                 r_eq, n_eq;

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        n_lt    = r_lt;
        n_eq    = r_eq;
        if (i_ctrl.cmp) begin
            n_lt = r_valid && ($signed(i_key) < $signed(r_key));
            n_eq = r_valid && (i_key == r_key);
        end
        if (i_ctrl.ins) begin
            // take the left key when the new key sorts before it, else drop in the new key;
            // an empty cell takes the new key only right after the last held one
            if (i_left_stat.lt) begin
                n_key   = i_left_key;
                n_valid = 1'b1;
            end else if (r_lt || (!r_valid && i_left_stat.valid)) begin
                n_key   = i_key;
                n_valid = 1'b1;
            end
        end
        if (i_ctrl.rem) begin
            // everything at or beyond the match pulls from the right
            if (r_lt || r_eq || !r_valid) begin
                n_key   = i_right_key;
                n_valid = i_right_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_lt  <= n_lt;
        r_eq  <= n_eq;
    end

    assign o_key        = r_key;
    assign o_stat.valid = r_valid;
    assign o_stat.lt    = r_lt;
    assign o_stat.eq    = r_eq;

endmodule

>>> rtl/unique_key_set_table_core.sv
// ----------------------------------------------------------------------------
// unique_key_set_table_core
// Bounded set of distinct signed keys held in a sorted chain of cells.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                 | Word
//  --------+-----------+---------------------------+-------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_cmd, i_key
//  out     | source    | o_out_valid / i_out_stall | o_status, o_found, o_count,
//          |           |                           | o_nonempty, o_min_key, o_max_key
//
//  Each word takes three steps: compare in every cell, update of the chain, load
//  of the output register. The single shared compare/update pass over the chain
//  admits the next word only once the last is loaded; a stalled output word delays that load.
//  Reset (synchronous, active low) empties the chain at once; no clearing pass.
//  The output register holds a finished word while the next input word is taken.
// ----------------------------------------------------------------------------
module unique_key_set_table_core
    import ukst_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [CMD_W-1:0]            i_cmd,
    input  logic signed [KEY_OUT_W-1:0] i_key,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [STATUS_W-1:0]         o_status,
    output logic                        o_found,
    output logic [COUNT_OUT_W-1:0]      o_count,
    output logic                        o_nonempty,
    output logic signed [KEY_OUT_W-1:0] o_min_key,
    output logic signed [KEY_OUT_W-1:0] o_max_key
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_UPD  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CMD_W-1:0]     r_cmd;
    logic [KEY_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]     r_count, n_count;
    t_status              r_status, n_status;
    logic                 r_found;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic                 r_out_found;
    logic [CNT_W-1:0]     r_out_count;
    logic                 r_out_nonempty;
    logic [KEY_WIDTH-1:0] r_out_min, r_out_max;

    logic [KEY_WIDTH-1:0] w_key_in;
    logic [KEY_WIDTH-1:0] w_cell_in;
    logic                 w_accept;
    logic                 w_out_load;
    logic                 w_hit;
    logic                 w_full;
    logic [KEY_WIDTH-1:0] w_max;
    t_cell_ctrl           w_ctrl;

    logic [KEY_WIDTH-1:0] w_cell_key  [CAPACITY];
    t_cell_stat           w_cell_stat [CAPACITY];

    // cut the port key to the table width; wider keys are zero extended
    if (KEY_WIDTH <= KEY_OUT_W) begin : g_key_cut
        assign w_key_in = i_key[KEY_WIDTH-1:0];
    end else begin : g_key_ext
        assign w_key_in = {{(KEY_WIDTH-KEY_OUT_W){1'b0}}, i_key};
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // compare against the port key on accept, against the held key afterwards
    assign w_cell_in = (r_state == S_IDLE) ? w_key_in : r_key;

    // ---- cell chain --------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_WIDTH-1:0] w_lkey, w_rkey;
        t_cell_stat           w_lstat;
        logic                 w_rvalid;

        if (g == 0) begin : g_left_end
            // the left end acts as a held neighbour, so an empty chain fills cell 0
            assign w_lkey  = '0;
            assign w_lstat = '{valid: 1'b1, lt: 1'b0, eq: 1'b0};
        end else begin : g_left
            assign w_lkey  = w_cell_key[g-1];
            assign w_lstat = w_cell_stat[g-1];
        end

        if (g == CAPACITY - 1) begin : g_right_end
            assign w_rkey   = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_right
            assign w_rkey   = w_cell_key[g+1];
            assign w_rvalid = w_cell_stat[g+1].valid;
        end

        ukst_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_key         (w_cell_in),
            .i_left_key    (w_lkey),
            .i_left_stat   (w_lstat),
            .i_right_key   (w_rkey),
            .i_right_valid (w_rvalid),
            .o_key         (w_cell_key[g]),
            .o_stat        (w_cell_stat[g])
        );
    end

    // keys stay packed and ascending from cell 0: the last valid cell is the maximum
    always_comb begin
        w_hit = 1'b0;
        w_max = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit = w_hit | w_cell_stat[i].eq;
            if (i == CAPACITY - 1) begin
                w_max = w_max | (w_cell_key[i] & {KEY_WIDTH{w_cell_stat[i].valid}});
            end else begin
                w_max = w_max | (w_cell_key[i] &
                         {KEY_WIDTH{w_cell_stat[i].valid && !w_cell_stat[i+1].valid}});
            end
        end
    end

    assign w_full = w_cell_stat[CAPACITY-1].valid;

    // ---- sequencer ---------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = r_status;
        w_ctrl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctrl.cmp = 1'b1;
                    n_state    = S_UPD;
                end
            end
            S_UPD: begin
                n_status = ST_OK;
                priority if (r_cmd == CMD_INSERT) begin
                    if (w_hit) begin
                        n_status = ST_DUP;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.ins = 1'b1;
                        n_count    = r_count + CNT_W'(1);
                    end
                end else if (r_cmd == CMD_REMOVE) begin
                    if (!w_hit) begin
                        n_status = ST_ABSENT;
                    end else begin
                        w_ctrl.rem = 1'b1;
                        n_count    = r_count - CNT_W'(1);
                    end
                end else begin
                    // query and the unused code only look the key up
                    n_status = ST_OK;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_key <= w_key_in;
        end
        r_status <= n_status;
        if (r_state == S_UPD) begin
            r_found <= w_hit;
        end
        if (w_out_load) begin
            r_out_status   <= r_status;
            r_out_found    <= r_found;
            r_out_count    <= r_count;
            r_out_nonempty <= w_cell_stat[0].valid;
            r_out_min      <= w_cell_stat[0].valid ? w_cell_key[0] : '0;
            r_out_max      <= w_max;
        end
    end

    // ---- output word -------------------------------------------------------
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found     = r_out_found;
    assign o_nonempty  = r_out_nonempty;

    // count wraps at the port width
    if (CNT_W >= COUNT_OUT_W) begin : g_cnt_cut
        assign o_count = r_out_count[COUNT_OUT_W-1:0];
    end else begin : g_cnt_ext
        assign o_count = {{(COUNT_OUT_W-CNT_W){1'b0}}, r_out_count};
    end

    // sign extend narrow keys, keep the low bits of wide ones
    if (KEY_WIDTH >= KEY_OUT_W) begin : g_out_cut
        assign o_min_key = r_out_min[KEY_OUT_W-1:0];
        assign o_max_key = r_out_max[KEY_OUT_W-1:0];
    end else begin : g_out_ext
        assign o_min_key = {{(KEY_OUT_W-KEY_WIDTH){r_out_min[KEY_WIDTH-1]}}, r_out_min};
        assign o_max_key = {{(KEY_OUT_W-KEY_WIDTH){r_out_max[KEY_WIDTH-1]}}, r_out_max};
    end

endmodule

>>> rtl/ukst_checker.sv
// ----------------------------------------------------------------------------
// ukst_checker
// Port-level checks of the unique key set table, bound to the top level.
// ----------------------------------------------------------------------------
module ukst_checker
    import ukst_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_stall,
    input  logic [CMD_W-1:0]            i_cmd,
    input  logic signed [KEY_OUT_W-1:0] i_key,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic [STATUS_W-1:0]         o_status,
    input  logic                        o_found,
    input  logic [COUNT_OUT_W-1:0]      o_count,
    input  logic                        o_nonempty,
    input  logic signed [KEY_OUT_W-1:0] o_min_key,
    input  logic signed [KEY_OUT_W-1:0] o_max_key
);

    // a duplicate insert means the key was there
    a_dup_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_DUP) |-> o_found)
        else $error("duplicate reported for a key not found");

    // a failed remove means the key was not there
    a_absent_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_ABSENT) |-> !o_found)
        else $error("not-present reported for a found key");

    // empty set shows zero extremes
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_nonempty |-> (o_min_key == 0) && (o_max_key == 0))
        else $error("empty set with nonzero min or max");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
        $stable(o_count) && $stable(o_min_key) && $stable(o_max_key))
        else $error("stalled result word changed");

endmodule

bind unique_key_set_table_core ukst_checker u_ukst_checker (.*);
